// ===== hw/rtl/pcmd_pkg.sv =====
// Shared types and constants for the PCM and G.711 sample decoder.
`timescale 1ns / 1ps

package pcmd_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int FORMAT_W   = 3;
	localparam int BITS_W     = 6;
	localparam int CFG_DATA_W = 6;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_FORMAT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_BITS   = 1'b1;

	localparam logic [SAMPLE_W-1:0] UNSIGNED_OFFSET = 32'h7fff_ffff;
	localparam logic [7:0]          ALAW_XOR        = 8'h55;
	localparam logic [15:0]         ALAW_BIAS       = 16'h0108;
	localparam logic [15:0]         MULAW_BIAS      = 16'h0084;
	localparam logic [7:0]          SEG_MASK        = 8'h70;

	localparam logic [BITS_W-1:0]   BITS_RESET      = 6'd16;
	localparam logic [BITS_W-1:0]   BITS_MAX        = 6'd32;

	typedef enum logic [FORMAT_W-1:0] {
		FMT_SIGNED_LE   = 3'd0,
		FMT_SIGNED_BE   = 3'd1,
		FMT_UNSIGNED_LE = 3'd2,
		FMT_UNSIGNED_BE = 3'd3,
		FMT_ALAW        = 3'd4,
		FMT_MULAW       = 3'd5
	} fmt_t;

endpackage

// ===== hw/rtl/pcmd_decode.sv =====
// Combinational conversion of one raw sample word into a left-aligned 32-bit sample.
`timescale 1ns / 1ps

module pcmd_decode (
	input  pcmd_pkg::fmt_t                       format,
	input  logic [pcmd_pkg::BITS_W-1:0]          sample_bits,
	input  logic [pcmd_pkg::SAMPLE_W-1:0]        raw,
	output logic signed [pcmd_pkg::SAMPLE_W-1:0] result
);
	import pcmd_pkg::*;

	logic [BITS_W-1:0]   bits_c;
	logic [BITS_W-1:0]   shift_full;
	logic [4:0]          shift;
	logic [2:0]          nbytes;
	logic [SAMPLE_W-1:0] be_word;
	logic [SAMPLE_W-1:0] le_aligned;
	logic [SAMPLE_W-1:0] be_aligned;

	logic [7:0]  a_byte;
	logic [2:0]  a_seg;
	logic [15:0] a_mag;
	logic [15:0] a_val;

	logic [7:0]  u_byte;
	logic [2:0]  u_seg;
	logic [15:0] u_mag;
	logic [15:0] u_val;

	always_comb begin
		if (sample_bits == '0) begin
			bits_c = 6'd1;
		end else if (sample_bits > BITS_MAX) begin
			bits_c = BITS_MAX;
		end else begin
			bits_c = sample_bits;
		end
		shift_full = BITS_MAX - bits_c;
		shift      = shift_full[4:0];
		nbytes     = bits_c[5:3] + {2'b00, |bits_c[2:0]};

		case (nbytes)
			3'd1:    be_word = {24'h0, raw[7:0]};
			3'd2:    be_word = {16'h0, raw[7:0], raw[15:8]};
			3'd3:    be_word = {8'h0, raw[7:0], raw[15:8], raw[23:16]};
			default: be_word = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
		endcase

		// Bytes past the sample width land above bit 'bits' and fall off the top.
		le_aligned = raw << shift;
		be_aligned = be_word << shift;

		a_byte = raw[7:0] ^ ALAW_XOR;
		a_seg  = 3'((a_byte & SEG_MASK) >> 4);
		if (a_seg == 3'd0) begin
			a_mag = {8'h00, a_byte[3:0], 4'h8};
		end else begin
			a_mag = ({8'h00, a_byte[3:0], 4'h0} + ALAW_BIAS) << (a_seg - 3'd1);
		end
		a_val = a_byte[7] ? a_mag : 16'(-a_mag);

		u_byte = ~raw[7:0];
		u_seg  = 3'((u_byte & SEG_MASK) >> 4);
		u_mag  = ({9'h000, u_byte[3:0], 3'b000} + MULAW_BIAS) << u_seg;
		u_val  = u_byte[7] ? 16'(MULAW_BIAS - u_mag) : 16'(u_mag - MULAW_BIAS);

		unique case (format)
			FMT_SIGNED_LE:   result = le_aligned;
			FMT_SIGNED_BE:   result = be_aligned;
			FMT_UNSIGNED_LE: result = le_aligned - UNSIGNED_OFFSET;
			FMT_UNSIGNED_BE: result = be_aligned - UNSIGNED_OFFSET;
			FMT_ALAW:        result = {a_val, 16'h0000};
			FMT_MULAW:       result = {u_val, 16'h0000};
			default:         result = '0;
		endcase
	end

endmodule

// ===== hw/rtl/pcm_sample_decoder.sv =====
// Top level of the PCM and G.711 sample decoder: configuration, pipeline and handshakes.
`timescale 1ns / 1ps

// Channel   Signals                                  Direction  Width
// sample    sample_valid, sample_stall, sample_bytes in         32
// result    result_valid, result_stall, sample_out   out        32 signed
// config    cfg_write_en, cfg_index, cfg_data        in         1 / 6
//
// One transaction is accepted every cycle when the output side keeps up.
// The raw word is registered, decoded in one pass and the sample is registered on the output.
// Reset clears both stage valids and sets the format to signed little-endian, 16 bits.
// A stall on the result side holds the output stage; the input stage still fills while it is empty.

module pcm_sample_decoder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write_en,
	input  logic [pcmd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pcmd_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic [pcmd_pkg::SAMPLE_W-1:0]        sample_bytes,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [pcmd_pkg::SAMPLE_W-1:0] sample_out
);
	import pcmd_pkg::*;

	fmt_t                       format_q;
	logic [BITS_W-1:0]          bits_q;
	logic                       valid_s1;
	logic [SAMPLE_W-1:0]        raw_s1;
	logic                       valid_s2;
	logic signed [SAMPLE_W-1:0] result_s2;
	logic signed [SAMPLE_W-1:0] decoded;
	logic                       advance;
	logic                       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_SIGNED_LE;
			bits_q   <= BITS_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_IDX_FORMAT: format_q <= fmt_t'(cfg_data[FORMAT_W-1:0]);
				CFG_IDX_BITS:   bits_q   <= cfg_data[BITS_W-1:0];
				default:        ;
			endcase
		end
	end

	assign advance      = !valid_s2 || !result_stall;
	assign sample_stall = valid_s1 && !advance;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_s1 <= sample_bytes;
		end
	end

	pcmd_decode u_decode (
		.format      (format_q),
		.sample_bits (bits_q),
		.raw         (raw_s1),
		.result      (decoded)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= decoded;
		end
	end

	assign result_valid = valid_s2;
	assign sample_out   = result_s2;

endmodule
